@@ src/graph_reachability_matrix_power_assert.svh @@
// Assertion macros for the reachability block
`ifndef GRAPH_REACHABILITY_MATRIX_POWER_ASSERT_SVH
`define GRAPH_REACHABILITY_MATRIX_POWER_ASSERT_SVH
// implication checked every clock outside reset
`define GRMP_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define GRMP_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ src/grmp_pkg.sv @@
// Shared constants and types for the reachability block
package grmp_pkg;
   localparam int MaxVertices = 64;
   localparam int VertexWidth = $clog2(MaxVertices);
   localparam int CountWidth  = 7;
   localparam logic ActionEdge  = 1'b0;
   localparam logic ActionQuery = 1'b1;

   typedef logic [VertexWidth-1:0] vertex_type;
   typedef logic [MaxVertices-1:0] row_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_STORE, ST_CHECK, ST_DONE
   } state_type;

   // control from sequencer to cell chain
   typedef struct packed {
      logic load;   // copy adjacency row into power cell
      logic shift;  // rotate power rows by one cell
      logic accum;  // OR power row into product if adjacency bit set
      logic clear;  // clear product accumulator
      logic commit; // move product into power row
   } cell_ctrl_type;
endpackage

@@ src/grmp_cell.sv @@
// One cell of the chain: holds one power row and one product accumulator
module grmp_cell (
   input  logic                   clock,
   input  grmp_pkg::cell_ctrl_type ctrl,
   input  grmp_pkg::row_type      adj_row,
   input  grmp_pkg::row_type      col_mask,
   input  grmp_pkg::row_type      prev_power,
   input  logic                   adj_bit,
   output grmp_pkg::row_type      power_row,
   output grmp_pkg::row_type      product_row
);
   grmp_pkg::row_type power_ff, power_in, prod_ff, prod_in;

   always_comb begin
      power_in = power_ff;
      prod_in  = prod_ff;
      if (ctrl.load) begin
         power_in = adj_row & col_mask;
      end else if (ctrl.shift) begin
         power_in = prev_power;
      end else if (ctrl.commit) begin
         power_in = prod_ff & col_mask;
      end
      // adj_bit selects the row this cell holds right now
      if (ctrl.clear) begin
         prod_in = '0;
      end else if (ctrl.accum && adj_bit) begin
         prod_in = prod_ff | power_ff;
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
      prod_ff  <= prod_in;
   end

   assign power_row   = power_ff;
   assign product_row = prod_ff;
endmodule

@@ src/grmp_chain.sv @@
// Ring of cells; power rows rotate so each cell sees every row k in turn
module grmp_chain (
   input  logic                    clock,
   input  grmp_pkg::cell_ctrl_type ctrl,
   input  grmp_pkg::row_type       adj_rows [grmp_pkg::MaxVertices],
   input  grmp_pkg::row_type       col_mask,
   input  grmp_pkg::vertex_type    k_index,
   input  grmp_pkg::vertex_type    src,
   output grmp_pkg::row_type       src_power,
   output grmp_pkg::row_type       src_product
);
   grmp_pkg::row_type power [grmp_pkg::MaxVertices];
   grmp_pkg::row_type prod  [grmp_pkg::MaxVertices];

   for (genvar i = 0; i < grmp_pkg::MaxVertices; i++) begin : g_cell
      // after k rotations cell i holds power row (i+k) mod N
      localparam int Next = (i + 1) % grmp_pkg::MaxVertices;
      grmp_pkg::vertex_type kcol;
      assign kcol = grmp_pkg::vertex_type'(i) + k_index;
      grmp_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .adj_row    (adj_rows[i]),
         .col_mask   (col_mask),
         .prev_power (power[Next]),
         .adj_bit    (adj_rows[i][kcol] & col_mask[kcol]),
         .power_row  (power[i]),
         .product_row(prod[i])
      );
   end

   assign src_power   = power[src];
   assign src_product = prod[src];
endmodule

@@ src/graph_reachability_matrix_power.sv @@
// Top level: edge store, sequencer and cell chain of the reachability block
// Usage:
//  req_ channel carries items: action 0 adds a directed edge, 1 asks for a path.
//  rsp_ channel returns one item per query: path_found in rsp_tdata[0].
//  csr_ port writes vertex_count (0 reads as 1, above 64 as 64).
//  An edge item is taken while idle. A query with n active vertices runs a
//  load and a check state, then for each of up to n-1 products the multiply
//  states, in which the power rows rotate once around the ring of 64 cells
//  while every cell ORs in the row it holds, then a store and a check state,
//  before the result item is offered. The ring length, not n, sets the
//  rotation time. A query with an endpoint outside the active vertices
//  offers its result the cycle after accept. The block stops early once
//  the path is found. One item is worked on at a time; req_tready is low
//  from query accept until its result item is taken. A stalled rsp_ holds
//  the result. Reset clears the adjacency matrix at once and sets
//  vertex_count to 64. Power and product rows need no clearing: each query
//  rewrites them.
module graph_reachability_matrix_power (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // action, source_vertex[6], target_vertex[6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // path_found
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata   // vertex_count
);
   `include "graph_reachability_matrix_power_assert.svh"
   localparam int VW = grmp_pkg::VertexWidth;
   localparam int CW = grmp_pkg::CountWidth;

   grmp_pkg::state_type state_ff, state_in;
   grmp_pkg::row_type adj_ff [grmp_pkg::MaxVertices];
   logic [CW-1:0] vcount_ff;
   logic [CW-1:0] n_eff;
   grmp_pkg::vertex_type src_ff, src_in, dst_ff, dst_in;
   grmp_pkg::vertex_type k_ff, k_in;
   logic [CW-1:0] step_ff, step_in;
   logic found_ff, found_in;
   grmp_pkg::row_type col_mask, src_power, src_product;
   grmp_pkg::cell_ctrl_type ctrl;
   logic req_acc;
   logic in_act;
   grmp_pkg::vertex_type in_src, in_dst;

   assign in_act = req_tdata[0];
   assign in_src = req_tdata[VW:1];
   assign in_dst = req_tdata[2*VW:VW+1];
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      if (vcount_ff == '0) n_eff = CW'(1);
      else if (vcount_ff > CW'(grmp_pkg::MaxVertices)) n_eff = CW'(grmp_pkg::MaxVertices);
      else n_eff = vcount_ff;
   end

   for (genvar c = 0; c < grmp_pkg::MaxVertices; c++) begin : g_mask
      assign col_mask[c] = (CW'(c) < n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CW'(grmp_pkg::MaxVertices);
         for (int r = 0; r < grmp_pkg::MaxVertices; r++) adj_ff[r] <= '0;
      end else begin
         if (csr_we) vcount_ff <= csr_wdata;
         if (req_acc && in_act == grmp_pkg::ActionEdge) adj_ff[in_src][in_dst] <= 1'b1;
      end
   end

   grmp_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .adj_rows   (adj_ff),
      .col_mask   (col_mask),
      .k_index    (k_ff),
      .src        (src_ff),
      .src_power  (src_power),
      .src_product(src_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grmp_pkg::ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      k_ff    <= k_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      k_in       = k_ff;
      step_in    = step_ff;
      found_in   = found_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         grmp_pkg::ST_IDLE: begin
            // req_tready is high here, so tvalid alone means accept
            req_tready = 1'b1;
            if (req_tvalid && in_act == grmp_pkg::ActionQuery) begin
               src_in = in_src;
               dst_in = in_dst;
               if (CW'(in_src) >= n_eff || CW'(in_dst) >= n_eff) begin
                  found_in = 1'b0;
                  state_in = grmp_pkg::ST_DONE;
               end else begin
                  state_in = grmp_pkg::ST_LOAD;
               end
            end
         end
         grmp_pkg::ST_LOAD: begin
            ctrl.load  = 1'b1;
            ctrl.clear = 1'b1;
            k_in       = '0;
            step_in    = CW'(1);
            state_in   = grmp_pkg::ST_CHECK;
         end
         grmp_pkg::ST_CHECK: begin
            // src_power holds A^step row of source
            if (src_power[dst_ff] || step_ff >= n_eff) begin
               found_in = src_power[dst_ff];
               state_in = grmp_pkg::ST_DONE;
            end else begin
               ctrl.clear = 1'b1;
               k_in       = '0;
               state_in   = grmp_pkg::ST_MUL;
            end
         end
         grmp_pkg::ST_MUL: begin
            // full turn of the ring, one shift per cell, restores row alignment
            ctrl.accum = 1'b1;
            ctrl.shift = 1'b1;
            k_in       = k_ff + VW'(1);
            if (k_ff == VW'(grmp_pkg::MaxVertices - 1)) state_in = grmp_pkg::ST_STORE;
         end
         grmp_pkg::ST_STORE: begin
            ctrl.commit = 1'b1;
            step_in     = step_ff + CW'(1);
            state_in    = grmp_pkg::ST_CHECK;
         end
         grmp_pkg::ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = grmp_pkg::ST_IDLE;
         end
         default: state_in = grmp_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tdata = {7'b0, found_ff};

   `GRMP_ASSERT_IMP(a_no_req_busy, clock, reset, state_ff != grmp_pkg::ST_IDLE, !req_tready)
   `GRMP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(found_ff))
   `GRMP_ASSERT_NXT(a_mul_wrap, clock, reset,
      state_ff == grmp_pkg::ST_MUL && k_ff == VW'(grmp_pkg::MaxVertices - 1),
      state_ff == grmp_pkg::ST_STORE)
endmodule

@@ bench/tb_top.sv @@
// Testbench for the adjacency-matrix-power reachability block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   graph_reachability_matrix_power i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   grmp_pkg::row_type adj_rows [grmp_pkg::MaxVertices];
   logic [6:0]  vcount;
   logic        found_q[$];
   int          mismatches;
   int          orphans;
   int          rsp_wait;

   function automatic logic predict_path(grmp_pkg::vertex_type src,
                                         grmp_pkg::vertex_type dst);
      grmp_pkg::row_type mask, pw [grmp_pkg::MaxVertices], pr [grmp_pkg::MaxVertices];
      int      n;
      n = (vcount == 0) ? 1 :
          (vcount > grmp_pkg::MaxVertices) ? grmp_pkg::MaxVertices : int'(vcount);
      if (src >= n || dst >= n) return 1'b0;
      mask = (n == grmp_pkg::MaxVertices) ? '1 : ((grmp_pkg::row_type'(1) << n) - 1);
      for (int i = 0; i < grmp_pkg::MaxVertices; i++) pw[i] = adj_rows[i] & mask;
      if (pw[src][dst]) return 1'b1;
      for (int s = 1; s < n; s++) begin
         for (int i = 0; i < n; i++) begin
            pr[i] = '0;
            for (int k = 0; k < n; k++)
               if (adj_rows[i][k]) pr[i] |= pw[k];
            pr[i] &= mask;
         end
         if (pr[src][dst]) return 1'b1;
         for (int i = 0; i < n; i++) pw[i] = pr[i];
      end
      return 1'b0;
   endfunction

   // tvalid stays up after accept only when the next item follows at once
   task automatic send_item(logic act, grmp_pkg::vertex_type src,
                            grmp_pkg::vertex_type dst);
      int gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, dst, src, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == grmp_pkg::ActionQuery) found_q.push_back(predict_path(src, dst));
      else adj_rows[src][dst] = 1'b1;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (found_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      vcount = value;
   endtask

   // receiver: per-item random wait, compare against oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = $urandom_range(0, 17);
      end else if (rsp_tvalid && rsp_tready) begin
         if (found_q.size() == 0) begin
            orphans++;
            if (mismatches + orphans <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            logic exp_found;
            exp_found = found_q.pop_front();
            if (rsp_tdata[0] !== exp_found) begin
               mismatches++;
               if (mismatches + orphans <= 10)
                  $display("path_found: expected %b got %b", exp_found, rsp_tdata[0]);
            end
         end
         rsp_wait = $urandom_range(0, 17);
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready) begin
         if (rsp_wait <= 1) rsp_tready <= 1'b1;
         else rsp_wait--;
      end
   end

   task automatic test_chain_and_loops;
      // chain 0->1->2->...; loop on 63; edges at top vertex
      for (int i = 0; i < 5; i++)
         send_item(grmp_pkg::ActionEdge, grmp_pkg::vertex_type'(i),
                   grmp_pkg::vertex_type'(i + 1));
      send_item(grmp_pkg::ActionEdge, 6'd63, 6'd63);
      send_item(grmp_pkg::ActionEdge, 6'd62, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd5);
      send_item(grmp_pkg::ActionQuery, 6'd5, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd63, 6'd63);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd62, 6'd3);
      send_item(grmp_pkg::ActionQuery, 6'd42, 6'd21);
      send_item(grmp_pkg::ActionEdge, 6'd5, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd3, 6'd3);
   endtask

   task automatic test_count_limits;
      write_count(7'd0);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd1);
      write_count(7'd1);
      send_item(grmp_pkg::ActionEdge, 6'd0, 6'd0);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd0);
      write_count(7'd3);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd2);
      send_item(grmp_pkg::ActionQuery, 6'd0, 6'd4);
      write_count(7'd127);
      send_item(grmp_pkg::ActionQuery, 6'd62, 6'd4);
      write_count(7'd64);
   endtask

   task automatic test_random;
      for (int p = 0; p < 4; p++) begin
         write_count((p == 3) ? 7'd64 : 7'($urandom_range(2, 12)));
         for (int j = 0; j < 20; j++) begin
            int lim;
            lim = (vcount > 0 && $urandom_range(0, 4) != 0) ? int'(vcount) - 1 : 63;
            send_item(logic'($urandom_range(0, 2) == 0),
                      grmp_pkg::vertex_type'($urandom_range(0, lim)),
                      grmp_pkg::vertex_type'($urandom_range(0, lim)));
         end
         drain();  // sender holds off until all results are back
      end
      write_count(7'($urandom));
      for (int j = 0; j < 10; j++)
         send_item(logic'($urandom), grmp_pkg::vertex_type'($urandom),
                   grmp_pkg::vertex_type'($urandom));
   endtask

   initial begin
      mismatches = 0;
      orphans = 0;
      vcount = 7'd64;
      foreach (adj_rows[i]) adj_rows[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_chain_and_loops();
      test_count_limits();
      test_random();
      drain();
      if (mismatches == 0 && orphans == 0 && found_q.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
